FILE: design/sos_pkg.sv
// Shared types, constants and helpers for the spiral order scan block.
// No dependencies; used by spiral_order_scan and sos_walker.
`timescale 1ns / 1ps

package sos_pkg;

   localparam int MAX_ROWS    = 8;
   localparam int MAX_COLUMNS = 8;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;
   localparam int DATA_W      = 32;
   localparam int SIZE_W      = 4;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int POS_W       = 3;
   localparam int COUNT_W     = ADDR_W + 1;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [SIZE_W-1:0]  size_type;
   typedef logic [COUNT_W-1:0] count_type;

   // register indexes on the csr port
   typedef enum logic {
      CSR_ROW_COUNT    = 1'b0,
      CSR_COLUMN_COUNT = 1'b1
   } csr_index_type;

   // geometry handed to the walker when a scan starts
   typedef struct packed {
      pos_type   bottom;
      pos_type   right;
      size_type  cols;
      count_type total;
   } walk_cfg_type;

   // zero reads as one, anything above the limit saturates
   function automatic size_type eff_size(input size_type reg_value, input size_type limit);
      size_type result;
      if (reg_value == '0) begin
         result = size_type'(1);
      end else if (reg_value > limit) begin
         result = limit;
      end else begin
         result = reg_value;
      end
      return result;
   endfunction

endpackage

FILE: design/spiral_order_scan.sv
// Spiral order scan, top level: load path, RAM, walker and output register.
// Depends on sos_pkg, sos_ram and sos_walker.
`timescale 1ns / 1ps

// Elements load one per cycle in row-major order into a 64-entry RAM; the
// transfer that completes a row_count x column_count matrix starts the scan.
// The scan then sends every element in clockwise spiral order, one per cycle
// when the consumer does not stall, with last_of_run on the final one: the
// rate is set by the walker's single address adder and the one RAM read port.
// While the scan issues its rows*cols reads the input is stalled; the walker
// start registers, the RAM read register and the output register lie between
// the transfer that completes the matrix and the first result on rsp_valid.
// Size registers read zero as one and saturate at eight, and take effect on
// the next input transfer.
module spiral_order_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_element_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_element_value_out,
   output logic               rsp_last_of_run,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [3:0]         csr_write_data
);

   typedef enum logic {
      ST_LOAD,
      ST_SCAN
   } state_type;

   state_type               state_ff, state_in;
   sos_pkg::size_type       row_count_ff, column_count_ff;
   sos_pkg::count_type      load_count_ff, load_count_in;
   logic                    pend_ff, pend_in, pend_last_ff, pend_last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [sos_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;

   sos_pkg::size_type       rows_eff, cols_eff;
   sos_pkg::count_type      total;
   sos_pkg::walk_cfg_type   walk_cfg;
   logic                    load_xfer, load_done;
   logic                    walk_busy, walk_last, issue, move;
   sos_pkg::addr_type       walk_addr;
   logic [sos_pkg::DATA_W-1:0] ram_rdata;

   assign rows_eff = sos_pkg::eff_size(row_count_ff, sos_pkg::size_type'(sos_pkg::MAX_ROWS));
   assign cols_eff = sos_pkg::eff_size(column_count_ff,
                                       sos_pkg::size_type'(sos_pkg::MAX_COLUMNS));
   assign total    = sos_pkg::count_type'(rows_eff) * sos_pkg::count_type'(cols_eff);

   assign walk_cfg.bottom = sos_pkg::pos_type'(rows_eff - sos_pkg::size_type'(1));
   assign walk_cfg.right  = sos_pkg::pos_type'(cols_eff - sos_pkg::size_type'(1));
   assign walk_cfg.cols   = cols_eff;
   assign walk_cfg.total  = total;

   assign req_stall = (state_ff != ST_LOAD);
   assign load_xfer = req_valid && !req_stall;
   assign load_done = load_xfer && ((load_count_ff + sos_pkg::count_type'(1)) >= total);

   // result path: one read in flight, output register in front of the consumer
   assign move  = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue = walk_busy && (!pend_ff || move);

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      if (load_done) begin
         load_count_in = '0;
         state_in      = ST_SCAN;
      end else if (load_xfer) begin
         load_count_in = load_count_ff + sos_pkg::count_type'(1);
      end
      if ((state_ff == ST_SCAN) && issue && walk_last) begin
         state_in = ST_LOAD;
      end

      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      if (issue) begin
         pend_in      = 1'b1;
         pend_last_in = walk_last;
      end else if (move) begin
         pend_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ram_rdata;
         rsp_last_in  = pend_last_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         load_count_ff   <= '0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         row_count_ff    <= sos_pkg::size_type'(sos_pkg::MAX_ROWS);
         column_count_ff <= sos_pkg::size_type'(sos_pkg::MAX_COLUMNS);
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               sos_pkg::CSR_ROW_COUNT:    row_count_ff    <= csr_write_data;
               sos_pkg::CSR_COLUMN_COUNT: column_count_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
      pend_last_ff <= pend_last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   sos_ram #(
      .WIDTH (sos_pkg::DATA_W),
      .DEPTH (sos_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_xfer),
      .wr_addr (load_count_ff[sos_pkg::ADDR_W-1:0]),
      .wr_data (req_element_value),
      .rd_en   (issue),
      .rd_addr (walk_addr),
      .rd_data (ram_rdata)
   );

   sos_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .start     (load_done),
      .start_cfg (walk_cfg),
      .advance   (issue),
      .busy      (walk_busy),
      .addr      (walk_addr),
      .last      (walk_last)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_element_value_out = rsp_data_ff;
   assign rsp_last_of_run       = rsp_last_ff;

   a_scan_means_walking: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> walk_busy)
      else $error("scan state without an active walker");

   // a size write may leave the count above the new total until the next transfer
   a_load_count_below_total: assert property (@(posedge clock) disable iff (reset)
      load_xfer && !load_done && !csr_write_enable |=> load_count_ff < total)
      else $error("load count reached matrix size without a scan");

   a_stalled_result_held: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid_ff) && $past(rsp_stall) && !$past(reset)
         |-> rsp_valid_ff && $stable(rsp_data_ff) && $stable(rsp_last_ff))
      else $error("stalled result changed");

endmodule

FILE: design/sos_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sos_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/sos_walker.sv
// Spiral address sequencer: walks the matrix clockwise with four shrinking
// bounds, one address per advance, using one shared address adder.
// Depends on sos_pkg.
`timescale 1ns / 1ps

module sos_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  sos_pkg::walk_cfg_type start_cfg,
   input  logic                  advance,
   output logic                  busy,
   output sos_pkg::addr_type     addr,
   output logic                  last
);

   typedef enum logic [1:0] {
      DIR_RIGHT,
      DIR_DOWN,
      DIR_LEFT,
      DIR_UP
   } dir_type;

   dir_type             dir_ff, dir_in;
   logic                busy_ff, busy_in;
   sos_pkg::pos_type    row_ff, row_in, col_ff, col_in;
   sos_pkg::pos_type    top_ff, top_in, bottom_ff, bottom_in;
   sos_pkg::pos_type    left_ff, left_in, right_ff, right_in;
   sos_pkg::size_type   cols_ff, cols_in;
   sos_pkg::count_type  remaining_ff, remaining_in;
   sos_pkg::addr_type   addr_ff, addr_in;
   sos_pkg::addr_type   step;
   sos_pkg::addr_type   cols_wide;

   assign cols_wide = sos_pkg::addr_type'(cols_ff);

   always_comb begin
      dir_in       = dir_ff;
      busy_in      = busy_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      top_in       = top_ff;
      bottom_in    = bottom_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      cols_in      = cols_ff;
      remaining_in = remaining_ff;
      step         = '0;
      if (start) begin
         dir_in       = DIR_RIGHT;
         busy_in      = 1'b1;
         row_in       = '0;
         col_in       = '0;
         top_in       = '0;
         left_in      = '0;
         bottom_in    = start_cfg.bottom;
         right_in     = start_cfg.right;
         cols_in      = start_cfg.cols;
         remaining_in = start_cfg.total;
      end else if (advance && busy_ff) begin
         remaining_in = remaining_ff - sos_pkg::count_type'(1);
         if (remaining_ff == sos_pkg::count_type'(1)) begin
            busy_in = 1'b0;
         end
         case (dir_ff)
            DIR_RIGHT: begin
               if (col_ff == right_ff) begin
                  top_in = top_ff + sos_pkg::pos_type'(1);
                  dir_in = DIR_DOWN;
                  row_in = row_ff + sos_pkg::pos_type'(1);
                  step   = cols_wide;
               end else begin
                  col_in = col_ff + sos_pkg::pos_type'(1);
                  step   = sos_pkg::addr_type'(1);
               end
            end
            DIR_DOWN: begin
               if (row_ff == bottom_ff) begin
                  right_in = right_ff - sos_pkg::pos_type'(1);
                  dir_in   = DIR_LEFT;
                  col_in   = col_ff - sos_pkg::pos_type'(1);
                  step     = '1;
               end else begin
                  row_in = row_ff + sos_pkg::pos_type'(1);
                  step   = cols_wide;
               end
            end
            DIR_LEFT: begin
               if (col_ff == left_ff) begin
                  bottom_in = bottom_ff - sos_pkg::pos_type'(1);
                  dir_in    = DIR_UP;
                  row_in    = row_ff - sos_pkg::pos_type'(1);
                  step      = -cols_wide;
               end else begin
                  col_in = col_ff - sos_pkg::pos_type'(1);
                  step   = '1;
               end
            end
            DIR_UP: begin
               if (row_ff == top_ff) begin
                  left_in = left_ff + sos_pkg::pos_type'(1);
                  dir_in  = DIR_RIGHT;
                  col_in  = col_ff + sos_pkg::pos_type'(1);
                  step    = sos_pkg::addr_type'(1);
               end else begin
                  row_in = row_ff - sos_pkg::pos_type'(1);
                  step   = -cols_wide;
               end
            end
            default: begin
               step = '0;
            end
         endcase
      end
   end

   // the one shared adder: moves the flat address by +-1 or +-cols
   assign addr_in = start ? '0 : addr_ff + step;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         dir_ff  <= DIR_RIGHT;
      end else begin
         busy_ff <= busy_in;
         dir_ff  <= dir_in;
      end
      row_ff       <= row_in;
      col_ff       <= col_in;
      top_ff       <= top_in;
      bottom_ff    <= bottom_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      cols_ff      <= cols_in;
      remaining_ff <= remaining_in;
      addr_ff      <= addr_in;
   end

   assign busy = busy_ff;
   assign addr = addr_ff;
   assign last = (remaining_ff == sos_pkg::count_type'(1));

   // incremental address must track row * cols + col
   a_addr_tracks_pos: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> addr_ff == sos_pkg::addr_type'(row_ff) * sos_pkg::addr_type'(cols_ff)
                            + sos_pkg::addr_type'(col_ff))
      else $error("walker address out of step with position");

   a_col_in_bounds: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (col_ff >= left_ff) && (col_ff <= right_ff))
      else $error("walker column outside bounds");

   a_row_in_bounds: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (row_ff >= top_ff) && (row_ff <= bottom_ff))
      else $error("walker row outside bounds");

   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> remaining_ff != '0)
      else $error("walker busy with nothing left");

endmodule
